// ===== rtl/sser_pkg.sv =====
// Shared types and constants for the SSI encoder reader.
`timescale 1ns / 1ps
`default_nettype none

package sser_pkg;

   // Field widths
   localparam int PosBitsW  = 5;
   localparam int PositionW = 31;
   localparam int ShiftW    = 32;
   localparam int TickW     = 8;
   localparam int FrameLenW = 6;

   // Release hold length after the last frame bit
   localparam int DefaultReleaseTicks = 32;

   // Register reset values
   localparam logic [PosBitsW-1:0] PosBitsReset   = 5'd16;
   localparam logic                AlarmPresReset = 1'b0;
   localparam logic                GrayReset      = 1'b0;

   // Register indexes, taken from paddr[3:2]
   localparam logic [1:0] RegPosBits   = 2'd0;
   localparam logic [1:0] RegAlarmPres = 2'd1;
   localparam logic [1:0] RegGray      = 2'd2;

   // Frame format settings
   typedef struct packed {
      logic [PosBitsW-1:0] position_bits;
      logic                alarm_present;
      logic                gray_coded;
   } cfg_type;

   // Decoded frame contents
   typedef struct packed {
      logic [PositionW-1:0] position;
      logic                 alarm;
   } frame_type;

endpackage

`default_nettype wire

// ===== rtl/sser_frame_decode.sv =====
// Frame decoder: strips the alarm bit, masks the position and, in Gray mode, Gray-decodes it.
`timescale 1ns / 1ps
`default_nettype none

module sser_frame_decode (
   input  wire logic [sser_pkg::ShiftW-1:0] shift_word,
   input  wire sser_pkg::cfg_type           cfg,
   output sser_pkg::frame_type              frame
);
   import sser_pkg::*;

   logic [ShiftW-1:0] pos_mask;
   logic [ShiftW-1:0] word;

   // Keep only the bits below position_bits
   always_comb begin
      for (int i = 0; i < ShiftW; i++) begin
         pos_mask[i] = (5'(i) < cfg.position_bits) && (i < ShiftW);
      end
   end

   // Prefix XOR in five doubling steps when the code is Gray
   always_comb begin
      word = shift_word & pos_mask;
      if (cfg.gray_coded) begin
         word = word ^ (word >> 1);
         word = word ^ (word >> 2);
         word = word ^ (word >> 4);
         word = word ^ (word >> 8);
         word = word ^ (word >> 16);
      end
      frame.position = word[PositionW-1:0];
      // Alarm bit sits just above the position and is active low
      frame.alarm    = ~shift_word[cfg.position_bits];
   end

endmodule

`default_nettype wire

// ===== rtl/ssi_encoder_reader_top.sv =====
// SSI absolute-encoder master: tick sequencer, frame capture and register port.
// Path: an accepted tick beat passes the input register, then the result register.
// Throughput: one tick beat per cycle while the result channel is ready;
// the phase sequencer updates once per tick.
// Reset: synchronous, active high; sequencer idle with the clock line high,
// held position and alarm cleared, registers back to 16 bits, no alarm, binary.
`timescale 1ns / 1ps
`default_nettype none

module ssi_encoder_reader_top #(
   parameter int RELEASE_TICKS = sser_pkg::DefaultReleaseTicks
) (
   input  wire logic        clock,
   input  wire logic        reset,
   // tick channel
   input  wire logic        req_tvalid,
   output logic             req_tready,
   input  wire logic [7:0]  req_tdata,   // [0] start_req, [1] data_in
   // result channel
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   output logic [39:0]      rsp_tdata,   // [0] clock_out, [1] busy_res, [2] frame_done,
                                         // [33:3] position, [34] alarm
   // register port
   input  wire logic        csr_psel,
   input  wire logic        csr_penable,
   input  wire logic        csr_pwrite,
   input  wire logic [3:0]  csr_paddr,
   input  wire logic [31:0] csr_pwdata,
   output logic [31:0]      csr_prdata,
   output logic             csr_pready
);
   import sser_pkg::*;

   localparam logic [TickW-1:0] RelTicks = TickW'(RELEASE_TICKS);

   typedef enum logic [1:0] {
      PH_LOW,
      PH_LATCH,
      PH_RECV,
      PH_RELEASE
   } phase_type;

   // Registers
   cfg_type              cfg_ff;
   logic                 in_valid_ff;
   logic                 in_start_ff;
   logic                 in_data_ff;
   logic                 rsp_valid_ff;
   logic [39:0]          rsp_data_ff;
   logic [39:0]          rsp_data_in;
   phase_type            phase_ff, phase_in;
   logic [TickW-1:0]     tick_ff, tick_in;
   logic                 clk_ff, clk_in;
   logic [ShiftW-1:0]    shift_ff, shift_in;
   logic                 active_ff, active_in;
   logic [PositionW-1:0] pos_ff, pos_in;
   logic                 alarm_ff, alarm_in;

   logic                 done;
   logic                 advance;
   logic                 cfg_write;
   logic [FrameLenW-1:0] frame_len;
   logic [ShiftW-1:0]    recv_word;
   frame_type            frame;

   // Register port
   assign csr_pready = 1'b1;
   assign cfg_write  = csr_psel && csr_penable && csr_pwrite && csr_pready;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.position_bits <= PosBitsReset;
         cfg_ff.alarm_present <= AlarmPresReset;
         cfg_ff.gray_coded    <= GrayReset;
      end else if (cfg_write) begin
         unique case (csr_paddr[3:2])
            RegPosBits:   cfg_ff.position_bits <= csr_pwdata[PosBitsW-1:0];
            RegAlarmPres: cfg_ff.alarm_present <= csr_pwdata[0];
            RegGray:      cfg_ff.gray_coded    <= csr_pwdata[0];
            default: ;
         endcase
      end
   end

   always_comb begin
      unique case (csr_paddr[3:2])
         RegPosBits:   csr_prdata = {27'd0, cfg_ff.position_bits};
         RegAlarmPres: csr_prdata = {31'd0, cfg_ff.alarm_present};
         RegGray:      csr_prdata = {31'd0, cfg_ff.gray_coded};
         default:      csr_prdata = 32'd0;
      endcase
   end

   // Handshake: input register feeds the result register
   assign advance    = in_valid_ff && (!rsp_valid_ff || rsp_tready);
   assign req_tready = !in_valid_ff || advance;
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

   // Frame length with alarm bit, never below one
   always_comb begin
      frame_len = {1'b0, cfg_ff.position_bits} + {5'd0, cfg_ff.alarm_present};
      if (frame_len == '0) begin
         frame_len = 6'd1;
      end
   end

   // Shift word after this tick's receive step: take a bit only while the clock is low
   assign recv_word = clk_ff ? shift_ff : {shift_ff[ShiftW-2:0], in_data_ff};

   sser_frame_decode u_decode (
      .shift_word (recv_word),
      .cfg        (cfg_ff),
      .frame      (frame)
   );

   // Phase sequencer for one tick
   always_comb begin
      phase_in  = phase_ff;
      tick_in   = tick_ff;
      clk_in    = clk_ff;
      shift_in  = shift_ff;
      active_in = active_ff | in_start_ff;
      pos_in    = pos_ff;
      alarm_in  = alarm_ff;
      done      = 1'b0;
      if (active_in) begin
         unique case (phase_ff)
            PH_LOW: begin
               clk_in   = 1'b0;
               tick_in  = '0;
               shift_in = '0;
               phase_in = PH_LATCH;
            end
            PH_LATCH: begin
               clk_in   = 1'b1;
               phase_in = PH_RECV;
            end
            PH_RECV: begin
               // shift on the low-to-high transition
               if (!clk_ff) begin
                  shift_in = recv_word;
                  tick_in  = tick_ff + 1'b1;
               end
               clk_in = ~clk_ff;
               if (tick_in >= {2'b00, frame_len}) begin
                  tick_in  = '0;
                  done     = 1'b1;
                  phase_in = PH_RELEASE;
                  pos_in   = frame.position;
                  if (cfg_ff.alarm_present) begin
                     alarm_in = frame.alarm;
                  end
               end
            end
            PH_RELEASE: begin
               if (tick_ff >= RelTicks) begin
                  active_in = 1'b0;
                  phase_in  = PH_LOW;
               end
               tick_in = tick_ff + 1'b1;
            end
            default: phase_in = PH_LOW;
         endcase
      end
      rsp_data_in = {5'd0, alarm_in, pos_in, done, active_in, clk_in};
   end

   // Control and sequencer state
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
         phase_ff     <= PH_LOW;
         tick_ff      <= '0;
         clk_ff       <= 1'b1;
         shift_ff     <= '0;
         active_ff    <= 1'b0;
         pos_ff       <= '0;
         alarm_ff     <= 1'b0;
      end else begin
         if (req_tready) begin
            in_valid_ff <= req_tvalid;
         end
         if (advance) begin
            rsp_valid_ff <= 1'b1;
            phase_ff     <= phase_in;
            tick_ff      <= tick_in;
            clk_ff       <= clk_in;
            shift_ff     <= shift_in;
            active_ff    <= active_in;
            pos_ff       <= pos_in;
            alarm_ff     <= alarm_in;
         end else if (rsp_tready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   // Beat payloads
   always_ff @(posedge clock) begin
      if (req_tvalid && req_tready) begin
         in_start_ff <= req_tdata[0];
         in_data_ff  <= req_tdata[1];
      end
      if (advance) begin
         rsp_data_ff <= rsp_data_in;
      end
   end

   // A finished frame is always reported while the read is still busy
   a_done_busy: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_data_ff[2] |-> rsp_data_ff[1])
      else $error("frame_done without busy");

   // Idle sequencer sits in the clock-low phase
   a_idle_phase: assert property (@(posedge clock) disable iff (reset)
      !active_ff |-> phase_ff == PH_LOW)
      else $error("idle sequencer outside clock-low phase");

   // A tick without a request leaves the held frame untouched
   a_idle_hold: assert property (@(posedge clock) disable iff (reset)
      advance && !active_ff && !in_start_ff |=> $stable(pos_ff) && $stable(alarm_ff))
      else $error("held frame changed on an idle tick");

   // Release phase ends before the tick counter passes the hold length
   a_release_bound: assert property (@(posedge clock) disable iff (reset)
      phase_ff == PH_RELEASE |-> tick_ff <= RelTicks)
      else $error("release count overran");

endmodule

`default_nettype wire

// ===== test/tb_top.sv =====
// Self-checking testbench for the SSI encoder reader: tick stream in, result stream checked.
`timescale 1ns / 1ps

module tb_top;
   import sser_pkg::*;

   localparam int CycleLimit  = 200000;
   localparam int QuietFirst  = 400;
   localparam int QuietLast   = 800;
   localparam int IdlePercent = 19;
   localparam int ReportMax   = 10;

   typedef enum logic [1:0] {SEQ_LOW, SEQ_LATCH, SEQ_RECV, SEQ_RELEASE} seq_phase_type;
   typedef enum int {DATA_RANDOM, DATA_ONES, DATA_ZEROS} data_style_type;

   // One tick beat, start_req in bit 0
   typedef struct packed {
      logic data_in;
      logic start_req;
   } tick_beat_type;

   // One result beat, clock_out in bit 0
   typedef struct packed {
      logic                 alarm;
      logic [PositionW-1:0] position;
      logic                 frame_done;
      logic                 busy_res;
      logic                 clock_out;
   } tick_result_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   wire         req_tready;
   logic [7:0]  req_tdata = '0;          // [0] start_req, [1] data_in
   wire         rsp_tvalid;
   logic        rsp_tready = 1'b0;
   wire  [39:0] rsp_tdata;               // [0] clock_out, [1] busy_res, [2] frame_done,
                                         // [33:3] position, [34] alarm
   logic        csr_psel = 1'b0;
   logic        csr_penable = 1'b0;
   logic        csr_pwrite = 1'b0;
   logic [3:0]  csr_paddr = '0;
   logic [31:0] csr_pwdata = '0;
   wire  [31:0] csr_prdata;
   wire         csr_pready;

   ssi_encoder_reader_top DUT (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   // Free-running clock
   initial begin
      forever #4 clock = ~clock;
   end

   tick_beat_type   pending_ticks[$];
   tick_result_type expected_results[$];
   int              cycle_count = 0;
   int              mismatch_count = 0;

   // Predictor copy of the frame format and sequencer state
   cfg_type              cfg = '{position_bits: PosBitsReset, alarm_present: AlarmPresReset,
                                 gray_coded: GrayReset};
   seq_phase_type        seq_phase = SEQ_LOW;
   logic [TickW-1:0]     seq_ticks = '0;
   logic                 seq_clk = 1'b1;
   logic [ShiftW-1:0]    seq_shift = '0;
   logic                 seq_active = 1'b0;
   logic [PositionW-1:0] held_pos = '0;
   logic                 held_alarm = 1'b0;

   wire quiet = (cycle_count >= QuietFirst) && (cycle_count < QuietLast);

   // Advance the sequencer by one tick and return the result it shows
   function automatic tick_result_type advance_sequencer(input logic start, input logic din);
      tick_result_type   r;
      logic [5:0]        frame_len;
      logic              done;
      logic [ShiftW-1:0] word;
      logic [ShiftW-1:0] pmask;
      done = 1'b0;
      frame_len = {1'b0, cfg.position_bits} + {5'b0, cfg.alarm_present};
      if (frame_len == 6'd0) frame_len = 6'd1;
      if (start && !seq_active) seq_active = 1'b1;
      if (seq_active) begin
         case (seq_phase)
            SEQ_LOW: begin
               seq_clk = 1'b0;
               seq_ticks = '0;
               seq_shift = '0;
               seq_phase = SEQ_LATCH;
            end
            SEQ_LATCH: begin
               seq_clk = 1'b1;
               seq_phase = SEQ_RECV;
            end
            SEQ_RECV: begin
               // shift on the low-to-high clock transition, MSB first
               if (!seq_clk) begin
                  seq_shift = {seq_shift[ShiftW-2:0], din};
                  seq_ticks = seq_ticks + 1'b1;
               end
               seq_clk = ~seq_clk;
               if (seq_ticks >= frame_len) begin
                  seq_ticks = '0;
                  word = seq_shift;
                  // alarm bit sits just above the position and is active low
                  if (cfg.alarm_present) held_alarm = ~word[cfg.position_bits];
                  pmask = (cfg.position_bits == 0) ? '0 :
                          (32'hFFFF_FFFF >> (32 - int'(cfg.position_bits)));
                  word = word & pmask;
                  // Gray decode: each bit is the XOR of itself and all bits above
                  if (cfg.gray_coded) begin
                     for (int i = ShiftW - 2; i >= 0; i--) word[i] = word[i] ^ word[i+1];
                  end
                  held_pos = word[PositionW-1:0];
                  done = 1'b1;
                  seq_phase = SEQ_RELEASE;
               end
            end
            default: begin
               if (seq_ticks >= DefaultReleaseTicks) begin
                  seq_active = 1'b0;
                  seq_phase = SEQ_LOW;
               end
               seq_ticks = seq_ticks + 1'b1;
            end
         endcase
      end
      r.clock_out  = seq_clk;
      r.busy_res   = seq_active;
      r.frame_done = done;
      r.position   = held_pos;
      r.alarm      = held_alarm;
      return r;
   endfunction

   // Cycle counter and run limit
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CycleLimit) begin
         $display("Simulation FAILED");
         $finish;
      end
   end

   // Driver: predict on each accepted beat, then offer the next one or idle
   always @(posedge clock) begin
      if (reset) begin
         req_tvalid <= 1'b0;
      end else begin
         if (req_tvalid && req_tready) begin
            expected_results.push_back(advance_sequencer(req_tdata[0], req_tdata[1]));
         end
         if (!req_tvalid || req_tready) begin
            if (pending_ticks.size() != 0 &&
                (quiet || $urandom_range(0, 99) >= IdlePercent)) begin
               req_tvalid <= 1'b1;
               req_tdata  <= {6'b0, pending_ticks.pop_front()};
            end else begin
               req_tvalid <= 1'b0;
            end
         end
      end
   end

   // Monitor: compare each accepted result beat against the oldest prediction
   always @(posedge clock) begin
      tick_result_type exp_r;
      tick_result_type got;
      if (reset) begin
         rsp_tready <= 1'b0;
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            got = rsp_tdata[34:0];
            if (expected_results.size() == 0) begin
               mismatch_count <= mismatch_count + 1;
               if (mismatch_count < ReportMax)
                  $display("unexpected result beat %h at cycle %0d",
                           rsp_tdata, cycle_count);
            end else begin
               exp_r = expected_results.pop_front();
               if (got.clock_out !== exp_r.clock_out || got.busy_res !== exp_r.busy_res ||
                   got.frame_done !== exp_r.frame_done || got.position !== exp_r.position ||
                   got.alarm !== exp_r.alarm) begin
                  mismatch_count <= mismatch_count + 1;
                  if (mismatch_count < ReportMax)
                     $display("mismatch at cycle %0d (exp/got): clk %b/%b busy %b/%b",
                              cycle_count, exp_r.clock_out, got.clock_out,
                              exp_r.busy_res, got.busy_res,
                              " done %b/%b pos %h/%h alarm %b/%b",
                              exp_r.frame_done, got.frame_done,
                              exp_r.position, got.position, exp_r.alarm, got.alarm);
               end
            end
         end
         rsp_tready <= quiet || ($urandom_range(0, 99) >= IdlePercent);
      end
   end

   // Write one register through a setup phase and an access phase
   task automatic write_reg(input logic [1:0] idx, input logic [31:0] val);
      @(posedge clock);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= {idx, 2'b00};
      csr_pwdata  <= val;
      @(posedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
      case (idx)
         RegPosBits:   cfg.position_bits = val[PosBitsW-1:0];
         RegAlarmPres: cfg.alarm_present = val[0];
         RegGray:      cfg.gray_coded    = val[0];
         default: ;
      endcase
   endtask

   // Hold until every beat is sent and every prediction is matched
   task automatic wait_drained();
      while (pending_ticks.size() != 0 || req_tvalid || expected_results.size() != 0)
         @(posedge clock);
   endtask

   // Set a frame format, then queue ticks for about one full read of it
   task automatic run_phase(input logic [4:0] pbits, input logic apres, input logic gray,
                            input data_style_type style);
      tick_beat_type b;
      int            count;
      wait_drained();
      write_reg(RegPosBits, {27'b0, pbits});
      write_reg(RegAlarmPres, {31'b0, apres});
      write_reg(RegGray, {31'b0, gray});
      count = 35 + 2 * (int'(pbits) + int'(apres));
      for (int i = 0; i < count; i++) begin
         b.start_req = ($urandom_range(0, 99) < 75);
         case (style)
            DATA_ONES:  b.data_in = ($urandom_range(0, 99) < 95);
            DATA_ZEROS: b.data_in = ($urandom_range(0, 99) < 5);
            default:    b.data_in = 1'($urandom_range(0, 1));
         endcase
         pending_ticks.push_back(b);
      end
   endtask

   // Stimulus: reset, directed ticks, then random phases over several formats
   initial begin
      repeat (8) @(posedge clock);
      reset <= 1'b0;

      // idle ticks first, then a read started under the reset format
      pending_ticks.push_back('{data_in: 1'b0, start_req: 1'b0});
      pending_ticks.push_back('{data_in: 1'b1, start_req: 1'b0});
      pending_ticks.push_back('{data_in: 1'b0, start_req: 1'b0});
      for (int i = 0; i < 20; i++)
         pending_ticks.push_back('{data_in: i[0], start_req: i[1]});

      // format changes may land mid-read, and then they take effect on the running frame
      run_phase(5'd1,  1'b1, 1'b0, DATA_RANDOM);
      run_phase(5'd31, 1'b1, 1'b1, DATA_ONES);
      run_phase(5'd0,  1'b1, 1'b1, DATA_RANDOM);
      run_phase(5'd0,  1'b0, 1'b0, DATA_RANDOM);
      run_phase(5'd31, 1'b0, 1'b0, DATA_ONES);
      run_phase(5'd31, 1'b1, 1'b0, DATA_ZEROS);
      run_phase(5'($urandom_range(0, 31)), 1'($urandom_range(0, 1)),
                1'($urandom_range(0, 1)), DATA_RANDOM);
      run_phase(5'($urandom_range(0, 31)), 1'($urandom_range(0, 1)),
                1'($urandom_range(0, 1)), DATA_RANDOM);

      wait_drained();
      repeat (10) @(posedge clock);
      if (mismatch_count == 0) begin
         $display("Simulation PASSED");
      end else begin
         $display("Simulation FAILED");
      end
      $finish;
   end

endmodule
